// File: design/ttp_pkg.sv
// shared types, codes and constants of the transposition table
package ttp_pkg;

   localparam int unsigned ENTRIES_DEF = 4096;

   typedef enum logic [1:0] {
      CMD_PROBE = 2'd0,
      CMD_PUT   = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_EXACT = 2'd0,
      KIND_ALPHA = 2'd1,
      KIND_BETA  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_NOMATCH = 3'd0,
      ST_USABLE  = 3'd1,
      ST_WRITTEN = 3'd2,
      ST_SKIPPED = 3'd3,
      ST_CLEARED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_SWEEP,
      FSM_IDLE,
      FSM_LOOKUP,
      FSM_CLR_RSP
   } fsm_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [63:0]        key;
      logic [7:0]         depth;
      logic signed [15:0] alpha;
      logic signed [15:0] beta;
      logic signed [15:0] score;
      logic [31:0]        best_move_in;
      logic [1:0]         bound_kind;
      logic               principal;
   } req_type;

   typedef struct packed {
      logic               principal;
      logic [7:0]         age;
      logic [1:0]         kind;
      logic [7:0]         depth;
      logic [31:0]        move;
      logic signed [15:0] score;
      logic [63:0]        key;
   } entry_type;

   typedef struct packed {
      logic               take;
      status_type         status;
      logic signed [15:0] score;
   } eval_type;

endpackage

// File: design/ttp_if.sv
// item channels of the transposition table
interface ttp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [63:0]        key;
   logic [7:0]         depth;
   logic signed [15:0] alpha;
   logic signed [15:0] beta;
   logic signed [15:0] score;
   logic [31:0]        best_move_in;
   logic [1:0]         bound_kind;
   logic               principal;

   modport source (output valid, cmd, key, depth, alpha, beta, score, best_move_in,
                   bound_kind, principal, input ready);
   modport sink (input valid, cmd, key, depth, alpha, beta, score, best_move_in,
                 bound_kind, principal, output ready);
endinterface

interface ttp_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [15:0] result_score;

   modport source (output valid, status, result_score, input ready);
   modport sink (input valid, status, result_score, output ready);
endinterface

// File: design/ttp_mem.sv
// slot memory, one write port and one registered read port
module ttp_mem #(
   parameter int unsigned ENTRIES = ttp_pkg::ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  ttp_pkg::entry_type         wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output ttp_pkg::entry_type         rd_data
);

   ttp_pkg::entry_type mem_ff [ENTRIES];
   ttp_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ttp_eval.sv
// probe answer and replacement decision on one slot read
module ttp_eval (
   input  ttp_pkg::req_type   req,
   input  ttp_pkg::entry_type slot,
   input  logic [7:0]         search_age,
   output ttp_pkg::eval_type  res,
   output ttp_pkg::entry_type new_entry
);

   logic key_eq;
   logic deep_enough;
   logic replace;

   assign key_eq      = slot.key == req.key;
   assign deep_enough = slot.depth >= req.depth;
   assign replace     = (slot.key == 64'd0) || (slot.age != search_age) || req.principal
                        || (!slot.principal && (req.depth >= slot.depth))
                        || (key_eq && (req.depth >= slot.depth));

   always_comb begin
      res = '{take: 1'b0, status: ttp_pkg::ST_NOMATCH, score: 16'sd0};
      unique case (req.cmd)
         ttp_pkg::CMD_PROBE: begin
            if (key_eq && deep_enough) begin
               priority if (slot.kind == ttp_pkg::KIND_EXACT) begin
                  res.status = ttp_pkg::ST_USABLE;
                  res.score  = slot.score;
               end else if (slot.kind == ttp_pkg::KIND_ALPHA && slot.score <= req.alpha) begin
                  res.status = ttp_pkg::ST_USABLE;
                  res.score  = req.alpha;
               end else if (slot.kind == ttp_pkg::KIND_BETA && slot.score >= req.beta) begin
                  res.status = ttp_pkg::ST_USABLE;
                  res.score  = req.beta;
               end else begin
                  res.status = ttp_pkg::ST_NOMATCH;
               end
            end
         end
         ttp_pkg::CMD_PUT: begin
            res.take   = replace;
            res.status = replace ? ttp_pkg::ST_WRITTEN : ttp_pkg::ST_SKIPPED;
         end
         default: begin
            res.status = ttp_pkg::ST_NOMATCH;
         end
      endcase
   end

   always_comb begin
      new_entry.principal = req.principal;
      new_entry.age       = search_age;
      new_entry.kind      = req.bound_kind;
      new_entry.depth     = req.depth;
      new_entry.move      = req.best_move_in;
      new_entry.score     = req.score;
      new_entry.key       = req.key;
   end

endmodule

// File: design/transposition_table_probe_put.sv
// direct-mapped transposition table: probe, put and clear over one slot memory
// probe or put: slot read at the accepting edge, result registered from LOOKUP once the output is free
// a new probe or put is taken only after the last one leaves LOOKUP: the slot is read, then written
// clear: sweeps ENTRIES slots, one per cycle, then gives its result from the CLR_RSP state
// reset: synchronous; all ENTRIES slots of the memory are swept with no item taken
// a result waiting on the output does not block taking the next item
module transposition_table_probe_put #(
   parameter int unsigned ENTRIES = ttp_pkg::ENTRIES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   ttp_req_if.sink         req_ch,
   ttp_rsp_if.source       rsp_ch,
   input  logic            csr_wr_en,
   input  logic [7:0]      csr_wr_data
);

   localparam int unsigned IDX_W = $clog2(ENTRIES);

   ttp_pkg::fsm_type   state_ff, state_in;
   logic [IDX_W-1:0]   sweep_cnt_ff, sweep_cnt_in;
   logic               clr_rsp_ff, clr_rsp_in;
   ttp_pkg::req_type   req_ff, req_in;
   logic [7:0]         search_age_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic signed [15:0] rsp_score_ff, rsp_score_in;

   ttp_pkg::req_type   req_cur;
   ttp_pkg::entry_type slot;
   ttp_pkg::entry_type new_entry;
   ttp_pkg::eval_type  ev;
   ttp_pkg::entry_type wr_data;
   logic [IDX_W-1:0]   wr_addr;
   logic               wr_en;
   logic               rd_en;
   logic               accept;
   logic               rsp_free;
   logic               rsp_load;
   logic               sweep_last;

   assign req_cur = '{cmd: req_ch.cmd, key: req_ch.key, depth: req_ch.depth,
                      alpha: req_ch.alpha, beta: req_ch.beta, score: req_ch.score,
                      best_move_in: req_ch.best_move_in, bound_kind: req_ch.bound_kind,
                      principal: req_ch.principal};

   assign req_ch.ready = state_ff == ttp_pkg::FSM_IDLE;
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign sweep_last   = &sweep_cnt_ff;

   ttp_mem #(.ENTRIES(ENTRIES)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (req_ch.key[IDX_W-1:0]),
      .rd_data (slot)
   );

   ttp_eval u_eval (
      .req        (req_ff),
      .slot       (slot),
      .search_age (search_age_ff),
      .res        (ev),
      .new_entry  (new_entry)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ttp_pkg::FSM_SWEEP: begin
            if (sweep_last) begin
               state_in = clr_rsp_ff ? ttp_pkg::FSM_CLR_RSP : ttp_pkg::FSM_IDLE;
            end
         end
         ttp_pkg::FSM_IDLE: begin
            if (accept) begin
               state_in = (req_ch.cmd == ttp_pkg::CMD_CLEAR) ? ttp_pkg::FSM_SWEEP
                                                             : ttp_pkg::FSM_LOOKUP;
            end
         end
         ttp_pkg::FSM_LOOKUP, ttp_pkg::FSM_CLR_RSP: begin
            if (rsp_free) begin
               state_in = ttp_pkg::FSM_IDLE;
            end
         end
         default: state_in = ttp_pkg::FSM_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      rd_en         = accept;
      wr_en         = 1'b0;
      wr_addr       = req_ff.key[IDX_W-1:0];
      wr_data       = new_entry;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_score_in  = rsp_score_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      clr_rsp_in    = clr_rsp_ff;
      req_in        = accept ? req_cur : req_ff;
      unique case (state_ff)
         ttp_pkg::FSM_SWEEP: begin
            wr_en        = 1'b1;
            wr_addr      = sweep_cnt_ff;
            wr_data      = '0;
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
         end
         ttp_pkg::FSM_IDLE: begin
            if (accept) begin
               sweep_cnt_in = '0;
               clr_rsp_in   = 1'b1;
            end
         end
         ttp_pkg::FSM_LOOKUP: begin
            if (rsp_free) begin
               wr_en         = ev.take;
               rsp_load      = 1'b1;
               rsp_status_in = ev.status;
               rsp_score_in  = ev.score;
            end
         end
         ttp_pkg::FSM_CLR_RSP: begin
            if (rsp_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = ttp_pkg::ST_CLEARED;
               rsp_score_in  = 16'sd0;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ttp_pkg::FSM_SWEEP;
         sweep_cnt_ff  <= '0;
         clr_rsp_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         search_age_ff <= 8'd0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            search_age_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rsp_status_ff <= rsp_status_in;
      rsp_score_ff  <= rsp_score_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.result_score = rsp_score_ff;

`ifndef NO_ASSERTIONS
   a_read_leads_to_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ttp_pkg::FSM_LOOKUP || state_ff == ttp_pkg::FSM_SWEEP))
      else $error("accepted item did not start a lookup or sweep");

   a_no_read_write_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("slot read and write in the same cycle");

   a_score_only_when_usable: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != ttp_pkg::ST_USABLE) |-> rsp_ch.result_score == 16'sd0)
      else $error("nonzero score without usable status");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> !$past(rsp_load))
      else $error("result overwritten while waiting");
`endif

endmodule

// File: dv/testbench.sv
// testbench of the transposition table: shadow table, random probe/put/clear traffic, checks
`timescale 1ns / 100ps

package ttp_tb_pkg;

   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   localparam logic [1:0] KIND_RESERVED = 2'd3;
   localparam int SLOT_BITS = $clog2(ttp_pkg::ENTRIES_DEF);

   typedef struct {
      ttp_pkg::status_type status;
      logic signed [15:0]  score;
   } answer_type;

   class tt_scoreboard;
      ttp_pkg::entry_type slots [ttp_pkg::ENTRIES_DEF];
      logic [7:0] age;
      answer_type answers [$];
      int errors, items, checked, probes_usable, puts_written, puts_skipped, clears;

      function new();
         wipe();
         age = '0;
         errors = 0;
         items = 0;
         checked = 0;
         probes_usable = 0;
         puts_written = 0;
         puts_skipped = 0;
         clears = 0;
      endfunction

      function void wipe();
         foreach (slots[i]) slots[i] = '0;
      endfunction

      function int pending();
         return answers.size();
      endfunction

      function void note_item(ttp_pkg::req_type r);
         answer_type           a;
         ttp_pkg::entry_type   e;
         logic [SLOT_BITS-1:0] idx;
         logic                 take;
         idx = r.key[SLOT_BITS-1:0];
         e = slots[idx];
         a.status = ttp_pkg::ST_NOMATCH;
         a.score = '0;
         items++;
         unique case (r.cmd)
            ttp_pkg::CMD_PROBE: begin
               if (e.key == r.key && e.depth >= r.depth) begin
                  if (e.kind == ttp_pkg::KIND_EXACT) begin
                     a.status = ttp_pkg::ST_USABLE;
                     a.score = e.score;
                  end else if (e.kind == ttp_pkg::KIND_ALPHA
                               && $signed(e.score) <= $signed(r.alpha)) begin
                     a.status = ttp_pkg::ST_USABLE;
                     a.score = r.alpha;
                  end else if (e.kind == ttp_pkg::KIND_BETA
                               && $signed(e.score) >= $signed(r.beta)) begin
                     a.status = ttp_pkg::ST_USABLE;
                     a.score = r.beta;
                  end
               end
               if (a.status == ttp_pkg::ST_USABLE) probes_usable++;
            end
            ttp_pkg::CMD_PUT: begin
               take = (e.key == '0) || (e.age != age) || r.principal
                  || (!e.principal && r.depth >= e.depth)
                  || (e.key == r.key && r.depth >= e.depth);
               if (take) begin
                  e.key = r.key;
                  e.score = r.score;
                  e.move = r.best_move_in;
                  e.depth = r.depth;
                  e.kind = r.bound_kind;
                  e.age = age;
                  e.principal = r.principal;
                  slots[idx] = e;
                  a.status = ttp_pkg::ST_WRITTEN;
                  puts_written++;
               end else begin
                  a.status = ttp_pkg::ST_SKIPPED;
                  puts_skipped++;
               end
            end
            ttp_pkg::CMD_CLEAR: begin
               wipe();
               a.status = ttp_pkg::ST_CLEARED;
               clears++;
            end
            default: ;
         endcase
         answers.push_back(a);
      endfunction

      function void check_result(logic [2:0] status, logic signed [15:0] score);
         answer_type a;
         if (answers.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("result with no item pending: status %0d score %0d", status, score);
            return;
         end
         a = answers.pop_front();
         checked++;
         if (status !== a.status || score !== a.score) begin
            errors++;
            if (errors <= 10)
               $display("mismatch on result %0d: expected status %0d score %0d, %s",
                        checked, a.status, a.score,
                        $sformatf("got status %0d score %0d", status, score));
         end
      endfunction
   endclass
endpackage

module testbench;

   localparam int QUIET_LIMIT = 20000;
   localparam int PHASE_ITEMS = 138;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;
   bit         calm;
   int         quiet;
   int         phases;
   logic [63:0] pool [24];
   logic [ttp_tb_pkg::SLOT_BITS-1:0] slot_set [8];
   logic [7:0] ages [8];

   ttp_tb_pkg::tt_scoreboard sb = new();

   ttp_req_if req_ch ();
   ttp_rsp_if rsp_ch ();

   transposition_table_probe_put dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (calm) return 0;
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      return $urandom_range(40, 5);
   endfunction

   function automatic logic [15:0] pick_value();
      int v;
      if ($urandom_range(9) == 0) return 16'($urandom);
      v = $urandom_range(160) - 80;
      return v[15:0];
   endfunction

   function automatic ttp_pkg::req_type mk(logic [1:0] c, logic [63:0] k, logic [7:0] d,
                                           logic [15:0] lo, logic [15:0] hi, logic [15:0] s,
                                           logic [31:0] mv, logic [1:0] bk, logic pv);
      ttp_pkg::req_type r;
      r.cmd = c;
      r.key = k;
      r.depth = d;
      r.alpha = lo;
      r.beta = hi;
      r.score = s;
      r.best_move_in = mv;
      r.bound_kind = bk;
      r.principal = pv;
      return r;
   endfunction

   function automatic ttp_pkg::req_type random_item();
      ttp_pkg::req_type r;
      int               roll;
      roll = $urandom_range(999);
      r.key = pool[$urandom_range(23)];
      r.depth = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(6));
      r.alpha = pick_value();
      r.beta = pick_value();
      r.score = pick_value();
      r.best_move_in = $urandom;
      r.bound_kind = ($urandom_range(19) == 0) ? ttp_tb_pkg::KIND_RESERVED
                                               : 2'($urandom_range(2));
      r.principal = ($urandom_range(3) == 0);
      if (roll < 460) begin
         r.cmd = ttp_pkg::CMD_PUT;
      end else if (roll < 920) begin
         r.cmd = ttp_pkg::CMD_PROBE;
      end else if (roll < 960) begin
         r.cmd = $urandom_range(1) ? ttp_pkg::CMD_PUT : ttp_pkg::CMD_PROBE;
         r.key = {$urandom, $urandom};
      end else if (roll < 980) begin
         r.cmd = $urandom_range(1) ? ttp_pkg::CMD_PUT : ttp_pkg::CMD_PROBE;
         r.key = '0;
      end else if (roll < 996) begin
         r.cmd = ttp_tb_pkg::CMD_UNUSED;
         r.key = {$urandom, $urandom};
      end else begin
         r.cmd = ttp_pkg::CMD_CLEAR;
      end
      return r;
   endfunction

   task automatic send_item(ttp_pkg::req_type r);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.cmd <= r.cmd;
      req_ch.key <= r.key;
      req_ch.depth <= r.depth;
      req_ch.alpha <= r.alpha;
      req_ch.beta <= r.beta;
      req_ch.score <= r.score;
      req_ch.best_move_in <= r.best_move_in;
      req_ch.bound_kind <= r.bound_kind;
      req_ch.principal <= r.principal;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic set_age(logic [7:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // result side stalls
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(5) == 0) stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      ttp_pkg::req_type seen;
      if (!reset) begin
         if (csr_wr_en) sb.age = csr_wr_data;
         if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.status, rsp_ch.result_score);
         if (req_ch.valid && req_ch.ready) begin
            seen.cmd = req_ch.cmd;
            seen.key = req_ch.key;
            seen.depth = req_ch.depth;
            seen.alpha = req_ch.alpha;
            seen.beta = req_ch.beta;
            seen.score = req_ch.score;
            seen.best_move_in = req_ch.best_move_in;
            seen.bound_kind = req_ch.bound_kind;
            seen.principal = req_ch.principal;
            sb.note_item(seen);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", quiet);
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      logic [63:0] k1, k2, k3;
      reset = 1'b1;
      calm = 1'b0;
      phases = 0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = '0;
      req_ch.key = '0;
      req_ch.depth = '0;
      req_ch.alpha = '0;
      req_ch.beta = '0;
      req_ch.score = '0;
      req_ch.best_move_in = '0;
      req_ch.bound_kind = '0;
      req_ch.principal = 1'b0;

      // few slots, several keys per slot, so entries collide and get replaced
      slot_set[0] = '0;
      slot_set[1] = '1;
      for (int i = 2; i < 8; i++)
         slot_set[i] = ttp_tb_pkg::SLOT_BITS'($urandom_range(ttp_pkg::ENTRIES_DEF - 1));
      for (int i = 0; i < 24; i++) begin
         pool[i] = {$urandom, $urandom};
         pool[i][ttp_tb_pkg::SLOT_BITS-1:0] = slot_set[i / 3];
      end
      k1 = pool[3];
      k2 = pool[4];
      k3 = pool[6];

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed
      send_item(mk(ttp_pkg::CMD_PROBE, '0, 8'd0, '0, '0, '0, '0, ttp_pkg::KIND_EXACT, 1'b0));
      send_item(mk(ttp_pkg::CMD_PROBE, '0, 8'd1, '0, '0, '0, '0, ttp_pkg::KIND_EXACT, 1'b0));
      send_item(mk(ttp_pkg::CMD_PUT, k1, 8'd255, '0, '0, 16'h7FFF, '0,
                   ttp_pkg::KIND_EXACT, 1'b0));
      send_item(mk(ttp_pkg::CMD_PROBE, k1, 8'd255, '0, '0, '0, '0,
                   ttp_pkg::KIND_EXACT, 1'b0));
      send_item(mk(ttp_pkg::CMD_PUT, k1, 8'd0, '0, '0, 16'h8000, '1,
                   ttp_pkg::KIND_ALPHA, 1'b0));
      send_item(mk(ttp_pkg::CMD_PUT, k1, 8'd3, '0, '0, 16'h8000, 32'h8000_0001,
                   ttp_pkg::KIND_ALPHA, 1'b1));
      send_item(mk(ttp_pkg::CMD_PROBE, k1, 8'd3, 16'h8000, '0, '0, '0,
                   ttp_pkg::KIND_EXACT, 1'b0));
      send_item(mk(ttp_pkg::CMD_PROBE, k1, 8'd4, 16'h7FFF, '0, '0, '0,
                   ttp_pkg::KIND_EXACT, 1'b0));
      send_item(mk(ttp_pkg::CMD_PUT, k2, 8'd10, '0, '0, 16'h7FFF, '0,
                   ttp_pkg::KIND_BETA, 1'b0));
      send_item(mk(ttp_pkg::CMD_PUT, k2, 8'd10, '0, '0, 16'h7FFF, '0,
                   ttp_pkg::KIND_BETA, 1'b1));
      send_item(mk(ttp_pkg::CMD_PROBE, k2, 8'd0, '0, 16'h7FFF, '0, '0,
                   ttp_pkg::KIND_EXACT, 1'b0));
      send_item(mk(ttp_pkg::CMD_PROBE, k2, 8'd0, '0, 16'h8000, '0, '0,
                   ttp_pkg::KIND_EXACT, 1'b0));
      send_item(mk(ttp_pkg::CMD_PROBE, k1, 8'd0, 16'h7FFF, 16'h8000, '0, '0,
                   ttp_pkg::KIND_EXACT, 1'b0));
      send_item(mk(ttp_pkg::CMD_PUT, k3, 8'd2, '0, '0, 16'd5, 32'h1234_5678,
                   ttp_tb_pkg::KIND_RESERVED, 1'b0));
      send_item(mk(ttp_pkg::CMD_PROBE, k3, 8'd0, 16'h7FFF, 16'h8000, '0, '0,
                   ttp_pkg::KIND_EXACT, 1'b0));
      send_item(mk(ttp_tb_pkg::CMD_UNUSED, k2, 8'd0, '0, '0, 16'd9, '0,
                   ttp_pkg::KIND_EXACT, 1'b0));
      send_item(mk(ttp_pkg::CMD_CLEAR, '0, '0, '0, '0, '0, '0, ttp_pkg::KIND_EXACT, 1'b0));
      send_item(mk(ttp_pkg::CMD_PROBE, k2, 8'd0, '0, 16'h8000, '0, '0,
                   ttp_pkg::KIND_EXACT, 1'b0));
      send_item(mk(ttp_pkg::CMD_PUT, '1, 8'd255, '0, '0, 16'hFFFF, '1,
                   ttp_pkg::KIND_EXACT, 1'b1));
      send_item(mk(ttp_pkg::CMD_PROBE, '1, 8'd255, 16'h7FFF, 16'h8000, '0, '0,
                   ttp_pkg::KIND_EXACT, 1'b0));
      send_item(mk(ttp_pkg::CMD_PUT, '0, 8'd0, '0, '0, '0, '0, ttp_pkg::KIND_EXACT, 1'b0));
      send_item(mk(ttp_pkg::CMD_PROBE, '0, 8'd0, '0, '0, '0, '0, ttp_pkg::KIND_EXACT, 1'b0));
      drain();

      ages[0] = 8'd255;
      ages[1] = 8'd0;
      ages[2] = 8'd1;
      ages[3] = 8'd254;
      ages[4] = 8'($urandom);
      ages[5] = 8'($urandom);
      ages[6] = 8'd128;
      ages[7] = 8'($urandom);
      for (int p = 0; p < 8; p++) begin
         set_age(ages[p]);
         calm = (p % 3 == 2);
         repeat (PHASE_ITEMS) send_item(random_item());
         drain();
         phases++;
      end
      calm = 1'b0;

      repeat (50) @(posedge clock);
      $display("covered %0d items over %0d age settings: %0d usable probes, %0d clears",
               sb.items, phases, sb.probes_usable, sb.clears);
      $display("puts: %0d written, %0d skipped; checked %0d results, %0d mismatches",
               sb.puts_written, sb.puts_skipped, sb.checked, sb.errors);
      if (sb.errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end
endmodule

// File: transposition_table_probe_put.f
design/ttp_pkg.sv
design/ttp_if.sv
design/ttp_mem.sv
design/ttp_eval.sv
design/transposition_table_probe_put.sv
dv/testbench.sv
